@@ rtl/u16u8_pkg.sv @@
// Shared types, constants and the UTF-8 encoding function of the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] SURR_LO     = 16'hd800;
   localparam logic [15:0] SURR_HI     = 16'hdfff;
   localparam logic [10:0] PLANE_BIAS  = 11'h040;
   localparam logic [20:0] LIMIT_ONE   = 21'h00080;
   localparam logic [20:0] LIMIT_TWO   = 21'h00800;
   localparam logic [20:0] LIMIT_THREE = 21'h10000;
   localparam logic [7:0]  LEAD_TWO    = 8'hc0;
   localparam logic [7:0]  LEAD_THREE  = 8'he0;
   localparam logic [7:0]  LEAD_FOUR   = 8'hf0;
   localparam logic [7:0]  CONT_MARK   = 8'h80;

   // Sequence length minus one.
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } seq_len_type;

   typedef struct packed {
      logic [3:0][7:0] seq_bytes;
      seq_len_type     seq_len;
   } seq_entry_type;

   function automatic seq_entry_type encode_code_point(input logic [20:0] cp);
      seq_entry_type e;
      e.seq_bytes = '0;
      if (cp < LIMIT_ONE) begin
         e.seq_len      = LEN_ONE;
         e.seq_bytes[0] = {1'b0, cp[6:0]};
      end else if (cp < LIMIT_TWO) begin
         e.seq_len      = LEN_TWO;
         e.seq_bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         e.seq_bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      end else if (cp < LIMIT_THREE) begin
         e.seq_len      = LEN_THREE;
         e.seq_bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         e.seq_bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         e.seq_bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      end else begin
         e.seq_len      = LEN_FOUR;
         e.seq_bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         e.seq_bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         e.seq_bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         e.seq_bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      end
      return e;
   endfunction

endpackage

@@ rtl/utf16_to_utf8_transcoder.sv @@
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_code_unit[15:0], req_last_unit
//   rsp_      out         rsp_valid/rsp_ready    rsp_out_byte[7:0], rsp_last_of_run
//
// Each code unit yields 1 to 3 UTF-8 bytes, or 4 for a surrogate pair (the held half
// yields nothing). The byte serializer at the back end sends one byte per cycle while
// the queue holds an entry and the output is not stalled.
// With the output free, an accepted unit passes through the queue and the output register.
// Synchronous reset clears the held surrogate, the queue and the output valid.
// A stalled output fills the queue, and req_ready drops only when it is full.
module utf16_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   logic                     q_full;
   logic                     q_push;
   u16u8_pkg::seq_entry_type q_push_entry;
   logic                     q_pop;
   logic                     q_head_valid;
   u16u8_pkg::seq_entry_type q_head_entry;

   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_push_entry  (q_push_entry)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   u16u8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_entry      (q_head_entry),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ rtl/u16u8_front.sv @@
// Front end: accepts code units, pairs surrogates and encodes each code point into a byte sequence.
module u16u8_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [15:0]              req_code_unit,
   input  logic                     req_last_unit,
   input  logic                     q_full,
   output logic                     q_push,
   output u16u8_pkg::seq_entry_type q_push_entry
);

   logic       pending_ff, pending_in;
   logic [9:0] high_bits_ff, high_bits_in;
   logic       accept;
   logic       is_surr;
   logic       hold;
   logic [20:0] code_point;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_surr   = (req_code_unit >= u16u8_pkg::SURR_LO) &&
                      (req_code_unit <= u16u8_pkg::SURR_HI);
   assign hold      = !pending_ff && is_surr && !req_last_unit;

   always_comb begin
      if (pending_ff) begin
         code_point = {{1'b0, high_bits_ff} + u16u8_pkg::PLANE_BIAS, req_code_unit[9:0]};
      end else begin
         code_point = {5'd0, req_code_unit};
      end
   end

   assign q_push       = accept && !hold;
   assign q_push_entry = u16u8_pkg::encode_code_point(code_point);

   always_comb begin
      pending_in   = pending_ff;
      high_bits_in = high_bits_ff;
      if (accept) begin
         pending_in = hold;
         if (hold) begin
            high_bits_in = req_code_unit[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         high_bits_ff <= '0;
      end else begin
         pending_ff   <= pending_in;
         high_bits_ff <= high_bits_in;
      end
   end

endmodule

@@ rtl/u16u8_queue.sv @@
// Short register queue of encoded byte sequences between front and back ends.
module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  u16u8_pkg::seq_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output u16u8_pkg::seq_entry_type head_entry
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);

   u16u8_pkg::seq_entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: sends queue head bytes one per unstalled cycle via an output register.
module u16u8_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  u16u8_pkg::seq_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       final_byte;

   assign load       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (idx_ff == head_entry.seq_len);
   assign pop        = load && final_byte;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         byte_in      = head_entry.seq_bytes[idx_ff];
         last_in      = final_byte;
         idx_in       = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

@@ rtl/u16u8_checker.sv @@
// Port-level checker of the transcoder and its bind to the top level.
module u16u8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last_of_run
);

   // Output valid drops right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Hold a stalled transaction.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_last_of_run))
      else $error("stalled rsp transaction changed");

   // Bytes of a multi-byte sequence follow without gaps.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a UTF-8 sequence");

   // ASCII bytes end a sequence, lead bytes never do.
   a_ascii_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_byte[7] |-> rsp_last_of_run)
      else $error("single-byte sequence not marked last");

   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte[7] && rsp_out_byte[6] |-> !rsp_last_of_run)
      else $error("lead byte marked last");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
